// ----- src/lfu_pkg.sv -----
// Shared types, widths and helpers for the LFU cache directory.
// No dependencies; imported by the top level.
`default_nettype none

package lfu_pkg;

    localparam int KEY_W     = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 5;
    localparam int IDX_OUT_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // One directory entry as stored in the slot RAM
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_slot_entry;

    localparam int ENTRY_W = $bits(t_slot_entry);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ----- src/lfu_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lfu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/lfu_cache_replacement.sv -----
// LFU cache directory, fully associative. Needs lfu_pkg and lfu_ram.
// Result: the strobe rises once the scan of the active slots and the DONE state are through;
//   the result transfers at the edge that ends the strobe cycle.
// One lookup at a time: a new one is accepted once the scan of the last one ends; the slot RAM is read one
//   slot per cycle through a single key/count compare that serves match and minimum.
// Reset (synchronous, active low): clears valid bits, totals, slots_in_use to 16.
// Results stay only until the next lookup completes: the receiver takes each one in its strobe cycle.
`default_nettype none

module lfu_cache_replacement #(
    parameter int SLOTS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfu_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [lfu_pkg::KEY_W-1:0]     i_lookup_key,
    output logic                               o_strobe,
    output logic                               o_was_hit,
    output logic [lfu_pkg::IDX_OUT_W-1:0]      o_slot_index,
    output logic [lfu_pkg::CNT_W-1:0]          o_evicted_count,
    output logic [lfu_pkg::CNT_W-1:0]          o_total_hits,
    output logic [lfu_pkg::CNT_W-1:0]          o_total_misses
);
    import lfu_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CFG_W-1:0] r_slots_in_use;
    logic [SLOTS-1:0] r_valid;
    logic [CNT_W-1:0] r_hit_total;
    logic [CNT_W-1:0] r_miss_total;
    logic             r_strobe;
    logic             r_ev_vld;
    logic [AW-1:0]    r_ev_idx;
    logic [CW-1:0]    r_rd_cnt;
    logic [CW-1:0]    r_n;
    logic             r_found;
    logic [KEY_W-1:0] r_key;
    logic [AW-1:0]    r_pick;
    logic [CNT_W-1:0] r_pick_cnt;
    logic             r_was_hit;
    logic [IDX_OUT_W-1:0] r_slot_idx;
    logic [CNT_W-1:0] r_evicted;

    logic [NW-1:0]    cfg_ext;
    logic [NW-1:0]    act_ext;
    logic [CW-1:0]    n_active;
    logic             accept;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic             ram_we;
    t_slot_entry      ram_wdata;
    t_slot_entry      rd_q;
    logic             ev_slot_valid;
    logic [CNT_W-1:0] cnt_eff;
    logic             ev_match;
    logic             scan_last;
    logic             done;

    // Active slot count: zero acts as one, above SLOTS clamps to SLOTS
    assign cfg_ext = NW'(r_slots_in_use);
    always_comb begin
        priority if (cfg_ext == '0) begin
            act_ext = NW'(1);
        end else if (cfg_ext > NW'(SLOTS)) begin
            act_ext = NW'(SLOTS);
        end else begin
            act_ext = cfg_ext;
        end
    end
    assign n_active = CW'(act_ext);

    assign busy   = (r_state == S_SCAN);
    assign accept = start && !busy;
    assign done   = (r_state == S_DONE);

    assign ram_re    = (r_state == S_SCAN) && (r_rd_cnt < r_n);
    assign ram_raddr = r_rd_cnt[AW-1:0];
    assign ram_we    = done;
    assign ram_wdata = '{key: r_key, cnt: r_found ? sat_inc(r_pick_cnt) : CNT_W'(1)};

    lfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pick),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_q)
    );

    // Empty slots never match and read as count zero
    assign ev_slot_valid = r_valid[r_ev_idx];
    assign cnt_eff       = ev_slot_valid ? rd_q.cnt : '0;
    assign ev_match      = ev_slot_valid && (rd_q.key == r_key);
    assign scan_last     = r_ev_vld && (r_rd_cnt == r_n);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = accept ? S_SCAN : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slots_in_use <= CFG_RESET;
            r_valid        <= '0;
            r_hit_total    <= '0;
            r_miss_total   <= '0;
            r_strobe       <= 1'b0;
            r_ev_vld       <= 1'b0;
            r_rd_cnt       <= '0;
            r_found        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= done;
            r_ev_vld <= ram_re;
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_wdata;
            end
            if (accept) begin
                r_rd_cnt <= '0;
                r_found  <= 1'b0;
            end else if (ram_re) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (r_ev_vld && !r_found && ev_match) begin
                r_found <= 1'b1;
            end
            if (done) begin
                r_valid[r_pick] <= 1'b1;
                if (r_found) begin
                    r_hit_total <= sat_inc(r_hit_total);
                end else begin
                    r_miss_total <= sat_inc(r_miss_total);
                end
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_ev_idx <= ram_raddr;
        if (accept) begin
            r_key <= i_lookup_key;
            r_n   <= n_active;
        end
        // first match wins; until then track the lowest count, ties to the lower slot
        if (r_ev_vld && !r_found) begin
            if (ev_match) begin
                r_pick     <= r_ev_idx;
                r_pick_cnt <= rd_q.cnt;
            end else if ((r_ev_idx == '0) || (cnt_eff < r_pick_cnt)) begin
                r_pick     <= r_ev_idx;
                r_pick_cnt <= cnt_eff;
            end
        end
        if (done) begin
            r_was_hit  <= r_found;
            r_slot_idx <= IDX_OUT_W'(r_pick);
            r_evicted  <= r_found ? '0 : r_pick_cnt;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_was_hit       = r_was_hit;
    assign o_slot_index    = r_slot_idx;
    assign o_evicted_count = r_evicted;
    assign o_total_hits    = r_hit_total;
    assign o_total_misses  = r_miss_total;

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished lookup");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= r_n) && (r_n != '0) && (r_n <= CW'(SLOTS)))
        else $error("scan counter out of range");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_was_hit) |-> (o_evicted_count == '0))
        else $error("hit reported with an evicted count");

    a_slot_valid_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_valid[$past(r_pick)])
        else $error("updated slot not marked valid");

endmodule

`default_nettype wire

// ----- tb/lfu_cache_replacement_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the LFU cache directory: directed and random lookups
// checked against an in-bench LFU predictor. Depends on lfu_pkg and lfu_cache_replacement.

module lfu_cache_replacement_tb;
    import lfu_pkg::*;

    localparam int DIR_SLOTS      = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = DIR_SLOTS + 8;
    localparam int MAX_REPORTS    = 40;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 155;
    localparam int POOL_MAX       = 32;

    localparam logic [KEY_W-1:0] KEY_ZERO = '0;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    typedef struct packed {
        logic                 was_hit;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [CNT_W-1:0]     evicted_count;
        logic [CNT_W-1:0]     total_hits;
        logic [CNT_W-1:0]     total_misses;
    } t_lookup_result;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata  = '0;
    logic                 start        = 1'b0;
    logic [KEY_W-1:0]     i_lookup_key = '0;
    logic                 busy;
    logic                 o_strobe;
    logic                 o_was_hit;
    logic [IDX_OUT_W-1:0] o_slot_index;
    logic [CNT_W-1:0]     o_evicted_count;
    logic [CNT_W-1:0]     o_total_hits;
    logic [CNT_W-1:0]     o_total_misses;

    lfu_cache_replacement #(
        .SLOTS(DIR_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_lookup_key   (i_lookup_key),
        .o_strobe       (o_strobe),
        .o_was_hit      (o_was_hit),
        .o_slot_index   (o_slot_index),
        .o_evicted_count(o_evicted_count),
        .o_total_hits   (o_total_hits),
        .o_total_misses (o_total_misses)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted directory state
    logic [KEY_W-1:0] dir_key   [DIR_SLOTS];
    bit               dir_valid [DIR_SLOTS];
    logic [CNT_W-1:0] dir_cnt   [DIR_SLOTS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CFG_W-1:0] slots_cfg;

    t_lookup_result expected_lookups[$];
    t_lookup_result got_result;
    t_lookup_result want_result;

    int mismatches      = 0;
    int lookups_sent    = 0;
    int results_checked = 0;
    int hits_checked    = 0;
    int cfg_writes      = 0;
    int idle_cycles     = 0;

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic t_lookup_result lfu_lookup(input logic [KEY_W-1:0] key);
        t_lookup_result   r;
        int               n;
        int               pick;
        bit               found;
        logic [CNT_W-1:0] best;
        n = (slots_cfg == 0) ? 1 : (slots_cfg > DIR_SLOTS) ? DIR_SLOTS : int'(slots_cfg);
        found = 1'b0;
        pick  = 0;
        r     = '0;
        for (int i = 0; i < n; i++) begin
            if (!found && dir_valid[i] && dir_key[i] == key) begin
                found = 1'b1;
                pick  = i;
            end
        end
        if (found) begin
            dir_cnt[pick] = bump(dir_cnt[pick]);
            hit_count     = bump(hit_count);
        end else begin
            // minimum scan, strict less-than keeps the lowest index on ties
            best = dir_cnt[0];
            for (int i = 1; i < n; i++) begin
                if (dir_cnt[i] < best) begin
                    best = dir_cnt[i];
                    pick = i;
                end
            end
            r.evicted_count = best;
            dir_key[pick]   = key;
            dir_valid[pick] = 1'b1;
            dir_cnt[pick]   = 1;
            miss_count      = bump(miss_count);
        end
        r.was_hit      = found;
        r.slot_index   = pick[IDX_OUT_W-1:0];
        r.total_hits   = hit_count;
        r.total_misses = miss_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] result %0d: %s got 0x%08h expected 0x%08h",
                     $realtime, results_checked, what, got, want);
        mismatches++;
    endtask

    // Result checker: outputs sampled at the edge that ends the strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            got_result = {o_was_hit, o_slot_index, o_evicted_count, o_total_hits,
                          o_total_misses};
            if (expected_lookups.size() == 0) begin
                report_mismatch("result with no lookup pending",
                                CNT_W'(got_result.slot_index), '0);
            end else begin
                want_result = expected_lookups.pop_front();
                if (got_result.was_hit !== want_result.was_hit)
                    report_mismatch("was_hit", CNT_W'(got_result.was_hit),
                                    CNT_W'(want_result.was_hit));
                if (got_result.slot_index !== want_result.slot_index)
                    report_mismatch("slot_index", CNT_W'(got_result.slot_index),
                                    CNT_W'(want_result.slot_index));
                if (got_result.evicted_count !== want_result.evicted_count)
                    report_mismatch("evicted_count", got_result.evicted_count,
                                    want_result.evicted_count);
                if (got_result.total_hits !== want_result.total_hits)
                    report_mismatch("total_hits", got_result.total_hits,
                                    want_result.total_hits);
                if (got_result.total_misses !== want_result.total_misses)
                    report_mismatch("total_misses", got_result.total_misses,
                                    want_result.total_misses);
                if (want_result.was_hit)
                    hits_checked++;
            end
            results_checked++;
        end
    end

    // Watchdog: cycles with neither a lookup transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called right after a rising edge; start stays high when gap is 0
    task automatic send_lookup(input logic [KEY_W-1:0] key, input int gap);
        start        <= 1'b1;
        i_lookup_key <= key;
        do @(posedge i_clk); while (busy);
        expected_lookups.push_back(lfu_lookup(key));
        lookups_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_lookups.size() != 0 || busy);
    endtask

    task automatic write_slots_in_use(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slots_cfg    = value;
        cfg_writes++;
    endtask

    // Zero acts as one slot; the empty directory must not match the reset key
    task automatic test_single_slot();
        write_slots_in_use(5'd0);
        send_lookup(KEY_ZERO, 1);
        send_lookup(KEY_ZERO, 0);
        send_lookup(KEY_ONES, 2);
    endtask

    // Empty slots go first, then smallest count, ties to lowest index
    task automatic test_victim_choice();
        write_slots_in_use(5'd3);
        send_lookup(32'h1234_5678, 0);
        send_lookup(32'h8765_4321, 1);
        send_lookup(KEY_ONES, 0);
        send_lookup(32'h1234_5678, 3);
        send_lookup(32'hDEAD_BEEF, 0);
        send_lookup(32'hCAFE_F00D, 1);
        send_lookup(32'hCAFE_F00D, 0);
        send_lookup(32'h0BAD_C0DE, 2);
    endtask

    // Counts above the slot total clamp to it
    task automatic test_clamped_slot_count();
        write_slots_in_use(5'd31);
        send_lookup(32'h1234_5678, 0);
        send_lookup(32'h0BAD_C0DE, 0);
        send_lookup(32'h1111_1111, 1);
    endtask

    // Inactive slots keep their contents across slot-count changes
    task automatic test_inactive_slots();
        write_slots_in_use(5'd1);
        send_lookup(32'h1234_5678, 1);
        write_slots_in_use(5'd17);
        send_lookup(32'h1234_5678, 0);
        send_lookup(32'h1111_1111, 2);
        write_slots_in_use(5'd2);
        send_lookup(32'h1111_1111, 1);
        write_slots_in_use(5'd16);
        send_lookup(32'h1111_1111, 0);
    endtask

    task automatic test_random_traffic();
        logic [KEY_W-1:0] key_pool[POOL_MAX];
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] cfg_value;
        int               pool_n;
        int               active_n;
        int               burst_left;
        int               gap;
        int               sel;
        int               idx;
        bit               no_idle;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       cfg_value = 5'd16;
                1:       cfg_value = 5'd1;
                2:       cfg_value = 5'd31;
                3:       cfg_value = 5'd0;
                4:       cfg_value = 5'd2;
                5:       cfg_value = 5'd17;
                6:       cfg_value = 5'd15;
                default: cfg_value = CFG_W'($urandom_range(0, 31));
            endcase
            write_slots_in_use(cfg_value);
            active_n = (cfg_value == 0) ? 1 : (cfg_value > DIR_SLOTS) ? DIR_SLOTS
                                                                      : int'(cfg_value);
            // pool of up to six keys more than the active slots (capped at POOL_MAX) brings evictions
            pool_n = $urandom_range(2, (active_n + 6 > POOL_MAX) ? POOL_MAX : active_n + 6);
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = $urandom;
            no_idle    = (phase % 4 == 1);
            burst_left = $urandom_range(1, 20);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 75) begin
                    // skewed pick so some keys are used far more often than others
                    key = key_pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
                end else if (sel < 82) begin
                    idx = $urandom_range(0, pool_n - 1);
                    key_pool[idx] = $urandom;
                    key = key_pool[idx];
                end else if (sel < 97) begin
                    key = $urandom;
                end else begin
                    key = $urandom_range(0, 1) ? KEY_ONES : KEY_ZERO;
                end
                burst_left--;
                if (burst_left == 0) begin
                    gap        = no_idle ? 0 : $urandom_range(1, 30);
                    burst_left = $urandom_range(1, 20);
                end else begin
                    gap = 0;
                end
                send_lookup(key, gap);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DIR_SLOTS; i++) begin
            dir_key[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_cnt[i]   = '0;
        end
        hit_count  = '0;
        miss_count = '0;
        slots_cfg  = CFG_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_slot();
        test_victim_choice();
        test_clamped_slot_count();
        test_inactive_slots();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d lookups (%0d hits, %0d misses) over %0d slot-count settings",
                 lookups_sent, hits_checked, results_checked - hits_checked, cfg_writes);
        $display("Checked %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
